### design/assert_macros.svh
// Assertion macros shared by the color conversion RTL.
// No dependencies; included by the modules that check their own pipelines.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rth_pkg.sv
// Shared constants for the RGB to HSL converter.
// No dependencies; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps

package rth_pkg;

  // Default channel width of one color component.
  localparam int unsigned CHANNEL_BITS_DEF = 8;
  // Default hue width: one full circle is 2**HUE_BITS.
  localparam int unsigned HUE_BITS_DEF     = 16;
  // Saturation is always a 16-bit fraction scaled by 2**16 - 1.
  localparam int unsigned SAT_BITS         = 16;

endpackage

### design/rth_pix_if.sv
// Pixel channel: one RGB word per handshake.
// Depends on rth_pkg for the default channel width.
`timescale 1ns / 1ps

interface rth_pix_if import rth_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) ();

  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

### design/rth_hsl_if.sv
// Result channel: one hue, saturation and lightness word per handshake.
// Depends on rth_pkg for default widths and the saturation width.
`timescale 1ns / 1ps

interface rth_hsl_if import rth_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int unsigned HUE_BITS     = HUE_BITS_DEF
) ();

  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [SAT_BITS-1:0]     saturation;
  logic [CHANNEL_BITS:0]   lightness_sum;

  modport source (output valid, output hue, output saturation, output lightness_sum,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness_sum,
                  output ready);

endinterface

### design/rth_div_step.sv
// One restoring division step: shift in a dividend bit, trial subtract.
// No dependencies; instantiated per stage by rth_divider.
`timescale 1ns / 1ps

module rth_div_step #(
  parameter int unsigned REM_BITS = 11
) (
  input  logic [REM_BITS-1:0] rem_i,
  input  logic [REM_BITS-1:0] div_i,
  input  logic                bit_i,
  output logic [REM_BITS-1:0] rem_o,
  output logic                q_o
);

  logic [REM_BITS:0]   shifted;
  logic [REM_BITS+1:0] diff;

  // The incoming remainder is below the divisor, so the shifted value is
  // below twice the divisor and one subtract settles the quotient bit.
  assign shifted = {rem_i, bit_i};
  assign diff    = {1'b0, shifted} - {2'b00, div_i};
  assign q_o     = ~diff[REM_BITS+1];
  assign rem_o   = q_o ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];

endmodule

### design/rth_front.sv
// Front end of the converter: max/min and sector pick, then the operands
// of both divisions, in three register stages. Depends on rth_pkg, rth_pix_if.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rth_front import rth_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rth_pix_if.sink                   pix_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [CHANNEL_BITS+2:0]   hrem_o,
  output logic [CHANNEL_BITS+2:0]   hdiv_o,
  output logic [CHANNEL_BITS:0]     srem_o,
  output logic [CHANNEL_BITS:0]     sden_o,
  output logic [SAT_BITS-1:0]       slow_o,
  output logic                      grey_o,
  output logic [CHANNEL_BITS:0]     sum_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam logic [CB:0] FULL  = {1'b0, {CB{1'b1}}};
  localparam logic [CB:0] FULL2 = {{CB{1'b1}}, 1'b0};

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic en1, en2, en3;

  // Stage 1 registers.
  logic           s1_v_q;
  logic [CB-1:0]  s1_mx_q, s1_mx_d;
  logic [CB-1:0]  s1_mn_q, s1_mn_d;
  sector_e        s1_sect_q, s1_sect_d;
  logic [CB:0]    s1_num_q, s1_num_d;

  // Stage 2 registers.
  logic           s2_v_q;
  logic [CB-1:0]  s2_delta_q, s2_delta_d;
  logic [CB:0]    s2_sum_q, s2_sum_d;
  logic [CB:0]    s2_den_q, s2_den_d;
  logic [CB+2:0]  s2_d6_q, s2_d6_d;
  logic [CB+3:0]  s2_x_q, s2_x_d;
  logic           s2_grey_q, s2_grey_d;
  logic [CB+2:0]  s2_off;

  // Stage 3 registers.
  logic                   s3_v_q;
  logic [CB+2:0]          s3_hrem_q, s3_hrem_d;
  logic [CB+2:0]          s3_d6_q;
  logic [CB+SAT_BITS-1:0] s3_satnum_q, s3_satnum_d;
  logic [CB:0]            s3_den_q;
  logic [CB:0]            s3_sum_q;
  logic                   s3_grey_q;
  logic [CB+3:0]          s3_wrap;

  assign en3         = ~s3_v_q | ready_i;
  assign en2         = ~s2_v_q | en3;
  assign en1         = ~s1_v_q | en2;
  assign pix_i.ready = en1;

  // Stage 1: largest and smallest channel; ties go to red, then green.
  always_comb begin
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      s1_sect_d = SECT_RED;
    end else if (pix_i.green >= pix_i.blue) begin
      s1_sect_d = SECT_GREEN;
    end else begin
      s1_sect_d = SECT_BLUE;
    end
    if (pix_i.red <= pix_i.green) begin
      s1_mn_d = (pix_i.red <= pix_i.blue) ? pix_i.red : pix_i.blue;
    end else begin
      s1_mn_d = (pix_i.green <= pix_i.blue) ? pix_i.green : pix_i.blue;
    end
    case (s1_sect_d)
      SECT_GREEN: begin
        s1_mx_d  = pix_i.green;
        s1_num_d = {1'b0, pix_i.blue} - {1'b0, pix_i.red};
      end
      SECT_BLUE: begin
        s1_mx_d  = pix_i.blue;
        s1_num_d = {1'b0, pix_i.red} - {1'b0, pix_i.green};
      end
      default: begin
        s1_mx_d  = pix_i.red;
        s1_num_d = {1'b0, pix_i.green} - {1'b0, pix_i.blue};
      end
    endcase
  end

  // Stage 2: delta, sum, the saturation denominator and the hue numerator
  // with its sector offset of 0, 2 or 4 times delta.
  always_comb begin
    s2_delta_d = s1_mx_q - s1_mn_q;
    s2_sum_d   = {1'b0, s1_mx_q} + {1'b0, s1_mn_q};
    s2_grey_d  = (s2_delta_d == '0);
    s2_d6_d    = {1'b0, s2_delta_d, 2'b00} + {2'b00, s2_delta_d, 1'b0};
    s2_den_d   = (s2_sum_d < FULL) ? s2_sum_d : (FULL2 - s2_sum_d);
    case (s1_sect_q)
      SECT_GREEN: s2_off = {2'b00, s2_delta_d, 1'b0};
      SECT_BLUE:  s2_off = {1'b0, s2_delta_d, 2'b00};
      default:    s2_off = '0;
    endcase
    s2_x_d = {1'b0, s2_off} + {{3{s1_num_q[CB]}}, s1_num_q};
  end

  // Stage 3: fold a negative hue numerator into [0, 6*delta), which only
  // drops whole circles, and form delta * (2**16 - 1) for saturation.
  always_comb begin
    s3_wrap     = s2_x_q + {1'b0, s2_d6_q};
    s3_hrem_d   = s2_x_q[CB+3] ? s3_wrap[CB+2:0] : s2_x_q[CB+2:0];
    s3_satnum_d = {s2_delta_q, {SAT_BITS{1'b0}}} - {{SAT_BITS{1'b0}}, s2_delta_q};
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= pix_i.valid;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_mx_q   <= s1_mx_d;
      s1_mn_q   <= s1_mn_d;
      s1_sect_q <= s1_sect_d;
      s1_num_q  <= s1_num_d;
    end
    if (en2) begin
      s2_delta_q <= s2_delta_d;
      s2_sum_q   <= s2_sum_d;
      s2_den_q   <= s2_den_d;
      s2_d6_q    <= s2_d6_d;
      s2_x_q     <= s2_x_d;
      s2_grey_q  <= s2_grey_d;
    end
    if (en3) begin
      s3_hrem_q   <= s3_hrem_d;
      s3_d6_q     <= s2_d6_q;
      s3_satnum_q <= s3_satnum_d;
      s3_den_q    <= s2_den_q;
      s3_sum_q    <= s2_sum_q;
      s3_grey_q   <= s2_grey_q;
    end
  end

  assign valid_o = s3_v_q;
  assign hrem_o  = s3_hrem_q;
  assign hdiv_o  = s3_d6_q;
  assign srem_o  = {1'b0, s3_satnum_q[CB+SAT_BITS-1:SAT_BITS]};
  assign slow_o  = s3_satnum_q[SAT_BITS-1:0];
  assign sden_o  = s3_den_q;
  assign grey_o  = s3_grey_q;
  assign sum_o   = s3_sum_q;

  // A colored pixel must leave a nonzero denominator no smaller than delta.
  `ASSERT_IMPLIES(a_den_covers_delta, clk_i, rst_ni, s2_v_q && !s2_grey_q, (s2_den_q != '0) && (s2_delta_q <= s2_den_q), "saturation denominator below delta")
  // The folded hue numerator must start the divider below its divisor.
  `ASSERT_IMPLIES(a_hue_rem_folded, clk_i, rst_ni, s3_v_q && !s3_grey_q, s3_hrem_q < s3_d6_q, "hue numerator not folded below six delta")

endmodule

### design/rth_divider.sv
// Pipelined restoring dividers for hue and saturation, one quotient bit
// per stage. Depends on rth_pkg and rth_div_step.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rth_divider import rth_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int unsigned HUE_BITS     = HUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [CHANNEL_BITS+2:0]   hrem_i,
  input  logic [CHANNEL_BITS+2:0]   hdiv_i,
  input  logic [CHANNEL_BITS:0]     srem_i,
  input  logic [CHANNEL_BITS:0]     sden_i,
  input  logic [SAT_BITS-1:0]       slow_i,
  input  logic                      grey_i,
  input  logic [CHANNEL_BITS:0]     sum_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [HUE_BITS-1:0]       hue_q_o,
  output logic [SAT_BITS-1:0]       sat_q_o,
  output logic                      grey_o,
  output logic [CHANNEL_BITS:0]     sum_o
);

  localparam int unsigned HR        = CHANNEL_BITS + 3;
  localparam int unsigned SR        = CHANNEL_BITS + 1;
  localparam int unsigned STAGES    = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
  localparam int unsigned HUE_START = STAGES - HUE_BITS;
  localparam int unsigned SAT_START = STAGES - SAT_BITS;

  logic [STAGES-1:0]   stg_v_q;
  logic [STAGES:0]     en;

  logic [HR-1:0]       stg_hrem_q [STAGES];
  logic [HR-1:0]       stg_hrem_d [STAGES];
  logic [HR-1:0]       stg_hdiv_q [STAGES];
  logic [HR-1:0]       stg_hdiv_d [STAGES];
  logic [HUE_BITS-1:0] stg_hq_q   [STAGES];
  logic [HUE_BITS-1:0] stg_hq_d   [STAGES];
  logic [SR-1:0]       stg_srem_q [STAGES];
  logic [SR-1:0]       stg_srem_d [STAGES];
  logic [SR-1:0]       stg_sden_q [STAGES];
  logic [SR-1:0]       stg_sden_d [STAGES];
  logic [SAT_BITS-1:0] stg_slow_q [STAGES];
  logic [SAT_BITS-1:0] stg_slow_d [STAGES];
  logic [SAT_BITS-1:0] stg_sq_q   [STAGES];
  logic [SAT_BITS-1:0] stg_sq_d   [STAGES];
  logic                stg_grey_q [STAGES];
  logic                stg_grey_d [STAGES];
  logic [SR-1:0]       stg_sum_q  [STAGES];
  logic [SR-1:0]       stg_sum_d  [STAGES];
  logic                stg_v_d    [STAGES];

  // The last stage is the output register; empty stages let words close up.
  assign en[STAGES] = ready_i;
  assign ready_o    = en[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                v_in;
    logic [HR-1:0]       hrem_in;
    logic [HR-1:0]       hdiv_in;
    logic [HUE_BITS-1:0] hq_in;
    logic [SR-1:0]       srem_in;
    logic [SR-1:0]       sden_in;
    logic [SAT_BITS-1:0] slow_in;
    logic [SAT_BITS-1:0] sq_in;
    logic                grey_in;
    logic [SR-1:0]       sum_in;

    assign en[k] = ~stg_v_q[k] | en[k+1];

    // Stage inputs come from the front end or from the previous stage.
    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign hrem_in = hrem_i;
      assign hdiv_in = hdiv_i;
      assign hq_in   = '0;
      assign srem_in = srem_i;
      assign sden_in = sden_i;
      assign slow_in = slow_i;
      assign sq_in   = '0;
      assign grey_in = grey_i;
      assign sum_in  = sum_i;
    end else begin : g_body
      assign v_in    = stg_v_q[k-1];
      assign hrem_in = stg_hrem_q[k-1];
      assign hdiv_in = stg_hdiv_q[k-1];
      assign hq_in   = stg_hq_q[k-1];
      assign srem_in = stg_srem_q[k-1];
      assign sden_in = stg_sden_q[k-1];
      assign slow_in = stg_slow_q[k-1];
      assign sq_in   = stg_sq_q[k-1];
      assign grey_in = stg_grey_q[k-1];
      assign sum_in  = stg_sum_q[k-1];
    end

    // Hue quotient bit; the shorter division idles in the leading stages.
    if (k >= HUE_START) begin : g_hue
      logic hq_bit;
      rth_div_step #(.REM_BITS(HR)) u_hue_step (
        .rem_i (hrem_in),
        .div_i (hdiv_in),
        .bit_i (1'b0),
        .rem_o (stg_hrem_d[k]),
        .q_o   (hq_bit)
      );
      assign stg_hq_d[k] = {hq_in[HUE_BITS-2:0], hq_bit};
    end else begin : g_hue_idle
      assign stg_hrem_d[k] = hrem_in;
      assign stg_hq_d[k]   = hq_in;
    end

    // Saturation quotient bit; the low dividend bits shift in MSB first.
    if (k >= SAT_START) begin : g_sat
      logic sq_bit;
      rth_div_step #(.REM_BITS(SR)) u_sat_step (
        .rem_i (srem_in),
        .div_i (sden_in),
        .bit_i (slow_in[SAT_BITS-1]),
        .rem_o (stg_srem_d[k]),
        .q_o   (sq_bit)
      );
      assign stg_sq_d[k]   = {sq_in[SAT_BITS-2:0], sq_bit};
      assign stg_slow_d[k] = {slow_in[SAT_BITS-2:0], 1'b0};
    end else begin : g_sat_idle
      assign stg_srem_d[k] = srem_in;
      assign stg_sq_d[k]   = sq_in;
      assign stg_slow_d[k] = slow_in;
    end

    assign stg_v_d[k]    = v_in;
    assign stg_hdiv_d[k] = hdiv_in;
    assign stg_sden_d[k] = sden_in;
    assign stg_grey_d[k] = grey_in;
    assign stg_sum_d[k]  = sum_in;
  end

  // Valid bits of all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (en[i]) stg_v_q[i] <= stg_v_d[i];
      end
    end
  end

  // Payload of all stages.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STAGES; i++) begin
      if (en[i]) begin
        stg_hrem_q[i] <= stg_hrem_d[i];
        stg_hdiv_q[i] <= stg_hdiv_d[i];
        stg_hq_q[i]   <= stg_hq_d[i];
        stg_srem_q[i] <= stg_srem_d[i];
        stg_sden_q[i] <= stg_sden_d[i];
        stg_slow_q[i] <= stg_slow_d[i];
        stg_sq_q[i]   <= stg_sq_d[i];
        stg_grey_q[i] <= stg_grey_d[i];
        stg_sum_q[i]  <= stg_sum_d[i];
      end
    end
  end

  assign valid_o = stg_v_q[STAGES-1];
  assign hue_q_o = stg_hq_q[STAGES-1];
  assign sat_q_o = stg_sq_q[STAGES-1];
  assign grey_o  = stg_grey_q[STAGES-1];
  assign sum_o   = stg_sum_q[STAGES-1];

  // Finished divisions leave a remainder below the divisor.
  `ASSERT_IMPLIES(a_hue_rem_final, clk_i, rst_ni, stg_v_q[STAGES-1] && !stg_grey_q[STAGES-1], stg_hrem_q[STAGES-1] < stg_hdiv_q[STAGES-1], "hue remainder not below divisor")
  `ASSERT_IMPLIES(a_sat_rem_final, clk_i, rst_ni, stg_v_q[STAGES-1] && !stg_grey_q[STAGES-1], stg_srem_q[STAGES-1] < stg_sden_q[STAGES-1], "saturation remainder not below divisor")
  // With the output register empty the whole enable chain must be open.
  `ASSERT_IMPLIES(a_empty_tail_ready, clk_i, rst_ni, !stg_v_q[STAGES-1], ready_o, "input blocked while output stage empty")

endmodule

### design/rgb_to_hsl_convert.sv
// RGB to HSL converter top level: front end, divider pipeline, output mux.
// Depends on rth_pkg, rth_pix_if, rth_hsl_if, rth_front and rth_divider.
`timescale 1ns / 1ps

// Converts RGB pixels into hue, saturation and lightness sum, one pixel per clock
// while the output is not stalled. Three stages find max, min and the division
// operands, then the hue and saturation quotients are built by restoring dividers
// that retire one quotient bit per register stage. Words enter back to back at one
// per clock; a stall at the output holds only the stages that are occupied, so the
// input keeps accepting words until the pipeline is full. Grey pixels report zero
// hue and zero saturation.
module rgb_to_hsl_convert import rth_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int unsigned HUE_BITS     = HUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rth_pix_if.sink     pix_i,
  rth_hsl_if.source   hsl_o
);

  logic                    fe_valid;
  logic                    fe_ready;
  logic [CHANNEL_BITS+2:0] fe_hrem;
  logic [CHANNEL_BITS+2:0] fe_hdiv;
  logic [CHANNEL_BITS:0]   fe_srem;
  logic [CHANNEL_BITS:0]   fe_sden;
  logic [SAT_BITS-1:0]     fe_slow;
  logic                    fe_grey;
  logic [CHANNEL_BITS:0]   fe_sum;

  logic                    dv_valid;
  logic [HUE_BITS-1:0]     dv_hue;
  logic [SAT_BITS-1:0]     dv_sat;
  logic                    dv_grey;
  logic [CHANNEL_BITS:0]   dv_sum;

  rth_front #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .valid_o (fe_valid),
    .ready_i (fe_ready),
    .hrem_o  (fe_hrem),
    .hdiv_o  (fe_hdiv),
    .srem_o  (fe_srem),
    .sden_o  (fe_sden),
    .slow_o  (fe_slow),
    .grey_o  (fe_grey),
    .sum_o   (fe_sum)
  );

  rth_divider #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .HUE_BITS     (HUE_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .ready_o (fe_ready),
    .hrem_i  (fe_hrem),
    .hdiv_i  (fe_hdiv),
    .srem_i  (fe_srem),
    .sden_i  (fe_sden),
    .slow_i  (fe_slow),
    .grey_i  (fe_grey),
    .sum_i   (fe_sum),
    .valid_o (dv_valid),
    .ready_i (hsl_o.ready),
    .hue_q_o (dv_hue),
    .sat_q_o (dv_sat),
    .grey_o  (dv_grey),
    .sum_o   (dv_sum)
  );

  // A grey pixel divided by zero; its quotients are replaced by zero.
  assign hsl_o.valid         = dv_valid;
  assign hsl_o.hue           = dv_grey ? '0 : dv_hue;
  assign hsl_o.saturation    = dv_grey ? '0 : dv_sat;
  assign hsl_o.lightness_sum = dv_sum;

endmodule

### sim/tb.sv
// Testbench for rgb_to_hsl_convert: directed, back-pressure and random pixel streams,
// each result checked against an in-bench HSL calculation.
// Depends on rth_pkg, rth_pix_if, rth_hsl_if and the converter RTL.
`timescale 1ns / 1ps

module tb;
  import rth_pkg::*;

  localparam int unsigned CB            = CHANNEL_BITS_DEF;
  localparam int unsigned HB            = HUE_BITS_DEF;
  localparam int unsigned CHAN_FULL     = (1 << CB) - 1;
  localparam int unsigned SAT_FULL      = (1 << SAT_BITS) - 1;
  // Input to output delay of one word with the default widths.
  localparam int unsigned PIPE_LATENCY  = 3 + ((HB > 16) ? HB : 16);
  localparam int unsigned HOLD_CYCLES   = 100;
  localparam int unsigned RANDOM_PIXELS = 420;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;

  typedef logic [CB-1:0] chan_t;

  typedef struct packed {
    logic [HB-1:0]       hue;
    logic [SAT_BITS-1:0] saturation;
    logic [CB:0]         lightness_sum;
  } hsl_word_t;

  logic clk_i;
  logic rst_ni;

  rth_pix_if pix ();
  rth_hsl_if hsl ();

  rgb_to_hsl_convert i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .hsl_o  (hsl)
  );

  hsl_word_t   hsl_expect_q[$];
  int unsigned mismatch_count = 0;
  // Receiver control: stall pattern on or off, and requests for a long hold-off.
  bit          rx_stall_on    = 1'b0;
  int unsigned hold_requests  = 0;

  // 100 MHz clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hue, saturation and lightness sum of one pixel.
  function automatic hsl_word_t predict_hsl(input chan_t r, input chan_t g, input chan_t b);
    logic [63:0] mx;
    logic [63:0] mn;
    logic [63:0] delta;
    logic [63:0] sum;
    logic [63:0] biased;
    logic [63:0] den;
    logic [63:0] quo;
    hsl_word_t   w;
    mx = 64'(r);
    mn = 64'(r);
    if (g > mx) mx = 64'(g);
    if (b > mx) mx = 64'(b);
    if (g < mn) mn = 64'(g);
    if (b < mn) mn = 64'(b);
    delta = mx - mn;
    sum   = mx + mn;
    w.lightness_sum = sum[CB:0];
    w.hue           = '0;
    w.saturation    = '0;
    if (delta != 0) begin
      // One full circle (6*delta) is added so the red sector never goes negative;
      // it drops out again when the quotient wraps. Ties go to red, then green.
      if (mx == r) begin
        biased = 6 * delta + g - b;
      end else if (mx == g) begin
        biased = 8 * delta + b - r;
      end else begin
        biased = 10 * delta + r - g;
      end
      quo   = (biased << HB) / (6 * delta);
      w.hue = quo[HB-1:0];
      // Saturation divides by the distance to the nearer end of the lightness range.
      den          = (sum < CHAN_FULL) ? sum : 2 * CHAN_FULL - sum;
      quo          = (delta * SAT_FULL) / den;
      w.saturation = quo[SAT_BITS-1:0];
    end
    return w;
  endfunction

  // Channel value biased toward the ends of the range.
  function automatic chan_t edge_channel();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return chan_t'(CHAN_FULL);
      default: return chan_t'($urandom);
    endcase
  endfunction

  // Offers one pixel word and records its expected result once accepted.
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    @(negedge clk_i);
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk_i); while (!pix.ready);
    hsl_expect_q.push_back(predict_hsl(r, g, b));
  endtask

  // Sender idles for the given number of cycles.
  task automatic pause_pixels(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      pix.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Sender stops until every outstanding result has come back.
  task automatic drain_results();
    pause_pixels(1);
    while (hsl_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, grey pixels, ties for the maximum and the saturation denominator switch.
  task automatic test_directed();
    rx_stall_on = 1'b0;
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd200, 8'd0,   8'd200);
    send_pixel(8'd0,   8'd200, 8'd200);
    // Red is largest with blue above green, so the hue wraps below zero.
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd200, 8'd100, 8'd150);
    send_pixel(8'd254, 8'd0,   8'd0);
    send_pixel(8'd128, 8'd127, 8'd127);
    send_pixel(8'd127, 8'd128, 8'd127);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd1);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'hAA,  8'h55,  8'h0F);
    send_pixel(8'h55,  8'hAA,  8'hF0);
    send_pixel(8'h0F,  8'hF0,  8'hAA);
    drain_results();
  endtask

  // Long output hold-off while words keep coming, so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    int unsigned n;
    rx_stall_on = 1'b0;
    hold_requests++;
    for (n = 0; n < 60; n++) begin
      send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    end
    drain_results();
  endtask

  // Random pixels in bursts with random gaps, against a stalling receiver.
  task automatic test_random_stream();
    int unsigned sent;
    int unsigned burst;
    chan_t       r;
    chan_t       g;
    chan_t       b;
    sent        = 0;
    rx_stall_on = 1'b1;
    while (sent < RANDOM_PIXELS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
        case ($urandom_range(0, 9))
          0: begin
            g = r;
            b = r;
          end
          1: begin
            case ($urandom_range(0, 2))
              0: g = r;
              1: b = g;
              default: b = r;
            endcase
          end
          2: begin
            r = edge_channel();
            g = edge_channel();
            b = edge_channel();
          end
          default: ;
        endcase
        send_pixel(r, g, b);
        sent++;
      end
      // Midway the sender waits for the pipeline to empty completely.
      if (sent >= RANDOM_PIXELS / 2 && sent - burst < RANDOM_PIXELS / 2) begin
        drain_results();
      end else begin
        pause_pixels(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
    end
    drain_results();
  endtask

  // Receiver ready: a random stall pattern, reloaded each time it has been played out, or a long hold-off.
  initial begin : rx_ready_gen
    int unsigned   hold_left;
    int unsigned   hold_grants;
    int unsigned   phase;
    logic [15:0]   pattern;
    hsl.ready   = 1'b0;
    hold_left   = 0;
    hold_grants = 0;
    phase       = 0;
    pattern     = '1;
    forever begin
      @(negedge clk_i);
      if (hold_grants != hold_requests) begin
        hold_grants++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        hsl.ready <= 1'b0;
      end else begin
        if (phase == 0) begin
          if (!rx_stall_on) begin
            pattern = '1;
          end else begin
            case ($urandom_range(0, 3))
              0: pattern = '1;
              1: pattern = 16'($urandom);
              2: pattern = 16'($urandom | $urandom);
              default: pattern = 16'($urandom & $urandom);
            endcase
          end
        end
        hsl.ready <= pattern[phase[3:0]];
        phase = (phase + 1) % 16;
      end
    end
  end

  // Compares each result word with the oldest expected one.
  always @(posedge clk_i) begin : hsl_checker
    hsl_word_t want;
    if (rst_ni && hsl.valid && hsl.ready) begin
      if (hsl_expect_q.size() == 0) begin
        $display("%0t: unexpected result hue %h saturation %h lightness_sum %h", $time,
                 hsl.hue, hsl.saturation, hsl.lightness_sum);
        mismatch_count++;
      end else begin
        want = hsl_expect_q.pop_front();
        if (hsl.hue !== want.hue) begin
          $display("%0t: hue expected %h actual %h", $time, want.hue, hsl.hue);
          mismatch_count++;
        end
        if (hsl.saturation !== want.saturation) begin
          $display("%0t: saturation expected %h actual %h", $time, want.saturation,
                   hsl.saturation);
          mismatch_count++;
        end
        if (hsl.lightness_sum !== want.lightness_sum) begin
          $display("%0t: lightness_sum expected %h actual %h", $time, want.lightness_sum,
                   hsl.lightness_sum);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("rgb_to_hsl_convert test failed");
    $finish;
  end

  // Test sequence.
  initial begin
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    rst_ni    = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_backpressure();
    test_random_stream();

    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (hsl_expect_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, hsl_expect_q.size());
    end
    if (mismatch_count == 0 && hsl_expect_q.size() == 0) begin
      $display("rgb_to_hsl_convert test passed");
    end else begin
      $display("rgb_to_hsl_convert test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/rth_pkg.sv
design/rth_pix_if.sv
design/rth_hsl_if.sv
design/rth_div_step.sv
design/rth_front.sv
design/rth_divider.sv
design/rgb_to_hsl_convert.sv
sim/tb.sv
